// File: rtl/dssb_pkg.sv
// Package for the dual stack shared buffer.
// Holds field widths, request and status codes, and the controller command
// and status structs. No dependencies.
package dssb_pkg;

  localparam int CAP_W  = 11;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 11'd1024;
  localparam logic [DATA_W-1:0] EMPTY_VALUE    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PUSH_VALUE_OUT = 32'h0000_0000;

  // Request kinds.
  localparam logic [1:0] REQ_PUSH_ONE = 2'd0;
  localparam logic [1:0] REQ_PUSH_TWO = 2'd1;
  localparam logic [1:0] REQ_POP_ONE  = 2'd2;
  localparam logic [1:0] REQ_POP_TWO  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load_req;     // capture the incoming request
    logic exec;         // update the counts, access the buffer, load the result
    logic capture_rd;   // load the popped value from the buffer read data
  } dssb_cmd_t;

  typedef struct packed {
    logic need_read;    // the request being executed pops a stored entry
  } dssb_sts_t;

endpackage

// File: rtl/dssb_ram.sv
// Generic single-port RAM with registered read data.
// Used for the shared stack buffer; no dependencies.
module dssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/dssb_ctrl.sv
// Controller state machine for the dual stack shared buffer.
// Sequences capture, execute, buffer read and result transfer; uses dssb_pkg.
module dssb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  dssb_pkg::dssb_sts_t sts,
  output dssb_pkg::dssb_cmd_t cmd
);
  import dssb_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_read ? S_RDWAIT : S_HOLD;
      end
      S_RDWAIT: begin
        cmd.capture_rd = 1'b1;
        state_next     = S_HOLD;
      end
      S_HOLD: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_HOLD);

endmodule

// File: rtl/dssb_dpath.sv
// Datapath for the dual stack shared buffer: capacity register, stack counts,
// request and result registers, and the shared buffer RAM. Uses dssb_pkg and dssb_ram.
module dssb_dpath #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dssb_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic [1:0]                  req_type,
  input  logic signed [dssb_pkg::DATA_W-1:0] push_value,
  output logic signed [dssb_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                  status,
  input  dssb_pkg::dssb_cmd_t         cmd,
  output dssb_pkg::dssb_sts_t         sts
);
  import dssb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]  capacity;
  logic [CW-1:0]     lower_count;
  logic [CW-1:0]     upper_count;
  logic [1:0]        req_kind;
  logic [DATA_W-1:0] req_value;

  logic [CW-1:0]     eff_cap;
  logic [CW:0]       used;
  logic              full;
  logic              lower_empty;
  logic              upper_empty;
  logic              is_push;
  logic              is_lower;
  logic              do_write;
  logic [CW-1:0]     pos;
  logic [DATA_W-1:0] ram_rdata;

  // Capacity above the buffer depth saturates at the depth.
  always_comb begin
    if (MW'(capacity) > MW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign used        = {1'b0, lower_count} + {1'b0, upper_count};
  assign full        = (used >= {1'b0, eff_cap});
  assign lower_empty = (lower_count == '0);
  assign upper_empty = (upper_count == '0) || (upper_count > eff_cap);
  assign is_push     = (req_kind == REQ_PUSH_ONE) || (req_kind == REQ_PUSH_TWO);
  assign is_lower    = (req_kind == REQ_PUSH_ONE) || (req_kind == REQ_POP_ONE);
  assign do_write    = cmd.exec && is_push && !full;

  always_comb begin
    case (req_kind)
      REQ_PUSH_ONE: pos = lower_count;
      REQ_PUSH_TWO: pos = eff_cap - upper_count - CW'(1);
      REQ_POP_ONE:  pos = lower_count - CW'(1);
      REQ_POP_TWO:  pos = eff_cap - upper_count;
      default:      pos = '0;
    endcase
  end

  assign sts.need_read = !is_push && (is_lower ? !lower_empty : !upper_empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // A capacity write empties both stacks, since stack two hangs from the old top.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      lower_count <= '0;
      upper_count <= '0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (!full) begin
          if (is_lower) begin
            lower_count <= lower_count + CW'(1);
          end else begin
            upper_count <= upper_count + CW'(1);
          end
        end
      end else if (sts.need_read) begin
        if (is_lower) begin
          lower_count <= lower_count - CW'(1);
        end else begin
          upper_count <= upper_count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind  <= req_type;
      req_value <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (is_push) begin
        pop_value <= PUSH_VALUE_OUT;
        status    <= full ? ST_FULL : ST_DONE;
      end else if (sts.need_read) begin
        pop_value <= PUSH_VALUE_OUT;
        status    <= ST_DONE;
      end else begin
        pop_value <= EMPTY_VALUE;
        status    <= ST_EMPTY;
      end
    end else if (cmd.capture_rd) begin
      pop_value <= ram_rdata;
    end
  end

  dssb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_buffer (
    .clk   (clk),
    .we    (do_write),
    .addr  (pos[AW-1:0]),
    .wdata (req_value),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/dual_stack_shared_buffer.sv
// Top level of the dual stack shared buffer.
// Instantiates dssb_ctrl and dssb_dpath; uses dssb_pkg.
//
// Two LIFO stacks share one buffer of DEPTH 32-bit entries, of which the
// capacity register selects how many are used (values above DEPTH act as
// DEPTH). Stack one grows up from entry 0, stack two grows down from entry
// capacity - 1. Each request yields one result: a push to a full buffer
// reports status 1 and is dropped, a pop of an empty stack returns -1 with
// status 2. Writing capacity empties both stacks. The buffer is a single-port
// RAM with a registered read, and one controller sequences each request: the
// result of a push or of a pop that finds its stack empty is valid in the hold
// state that follows the execute state, and a pop that reads the buffer passes
// through a read-wait state between the two. No new request is taken until the
// result has been transferred and the controller is back in idle, so requests
// never overlap.
module dual_stack_shared_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dssb_pkg::CAP_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic signed [dssb_pkg::DATA_W-1:0] push_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dssb_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                         status
);
  import dssb_pkg::*;

  dssb_cmd_t cmd;
  dssb_sts_t sts;

  dssb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dssb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_type   (req_type),
    .push_value (push_value),
    .pop_value  (pop_value),
    .status     (status),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
